FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ITDA_ASSERT_CR(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion on clk and rst_n.
`define ITDA_ASSERT(lbl, prop, msg) \
    `ITDA_ASSERT_CR(lbl, clk, rst_n, prop, msg)

`endif

FILE: src/itda_pkg.sv
package itda_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int BITS_PER_STEP       = 4;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_COUNT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic count;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic last_digit;
    } status_t;

endpackage

FILE: src/itda_ctrl.sv
module itda_ctrl
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int CNT_W = $clog2(STEPS);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   step_next;
    logic               conv_last;

    assign conv_last = (step_reg == CNT_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                step_next = step_reg + CNT_W'(1);
                if (conv_last)
                begin
                    state_next = S_COUNT;
                    step_next  = '0;
                end
            end
            S_COUNT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.last_digit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_CONV:
            begin
                cmd.conv      = 1'b1;
                cmd.emit_sign = status.neg && (step_reg == '0);
            end
            S_COUNT:
            begin
                cmd.count = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit_digit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/itda_dp.sv
module itda_dp
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  cmd_t                          cmd,
    output status_t                       status,
    output logic                          strobe,
    output logic [7:0]                    character,
    output logic                          last
);

    localparam int STEPS = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int MAG_W = STEPS * BITS_PER_STEP;
    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int IDX_W = $clog2(NDIG);

    logic [VALUE_WIDTH-1:0]  value_u;
    logic [VALUE_WIDTH-1:0]  abs_val;
    logic [MAG_W-1:0]        mag_reg;
    logic [MAG_W-1:0]        mag_next;
    logic [NDIG-1:0][3:0]    bcd_reg;
    logic [NDIG-1:0][3:0]    bcd_next;
    logic [NDIG-1:0][3:0]    bcd_work;
    logic                    neg_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [IDX_W-1:0]        idx_calc;
    logic                    strobe_reg;
    logic [7:0]              char_reg;
    logic [7:0]              char_next;
    logic                    last_reg;
    logic                    last_next;

    assign value_u = value;
    assign abs_val = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;

    // Four double-dabble steps per cycle, one magnitude bit each.
    always_comb
    begin
        bcd_work = bcd_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (bcd_work[d] >= 4'd5)
                begin
                    bcd_work[d] = bcd_work[d] + 4'd3;
                end
            end
            bcd_work = BCD_W'({bcd_work, mag_reg[MAG_W-1-b]});
        end
    end

    always_comb
    begin
        idx_calc = '0;
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                idx_calc = IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        idx_next  = idx_reg;
        char_next = char_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            mag_next = MAG_W'(abs_val);
            bcd_next = '0;
        end
        if (cmd.conv)
        begin
            mag_next = mag_reg << BITS_PER_STEP;
            bcd_next = bcd_work;
        end
        if (cmd.count)
        begin
            idx_next = idx_calc;
        end
        if (cmd.emit_sign)
        begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            char_next = CHAR_ZERO + 8'(bcd_reg[idx_reg]);
            last_next = (idx_reg == '0);
            idx_next  = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign || cmd.emit_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if (cmd.load)
        begin
            neg_reg <= value_u[VALUE_WIDTH-1];
        end
    end

    assign status.neg        = neg_reg;
    assign status.last_digit = (idx_reg == '0);
    assign strobe            = strobe_reg;
    assign character         = char_reg;
    assign last              = last_reg;

endmodule

FILE: src/int_to_decimal_ascii_unit.sv
// Signed integer to decimal ASCII text converter.
// A request is issued by raising start with the integer on value; it is taken
// at a rising edge where start is high and busy is low. Busy stays high until
// the converter can take the next request.
// Results leave one character per strobe cycle on character and last: a '-'
// first for negative values, then the digits most significant first without
// leading zeros, with last marking the final digit. Zero gives a single '0'.
// The magnitude is converted by shift-and-add-three, four bits per cycle, and the
// sign, if any, is emitted while conversion runs. After conversion a count state
// locates the leading digit, and then one digit leaves per cycle.
// The receiver cannot stall: each character is shown for one cycle only.
// Reset returns the controller to idle and clears the strobe; no character
// is in flight afterwards.
module int_to_decimal_ascii_unit
    import itda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          strobe,
    output logic [7:0]                    character,
    output logic                          last
);

    cmd_t    cmd;
    status_t status;

    itda_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy)
    );

    itda_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .status   (status),
        .strobe   (strobe),
        .character(character),
        .last     (last)
    );

endmodule

FILE: src/itda_checker.sv
`include "assert_macros.svh"

module itda_checker
    import itda_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] character,
    input logic       last
);

    logic char_ok;

    assign char_ok = (character == CHAR_MINUS) ||
                     ((character >= CHAR_ZERO) && (character <= CHAR_NINE));

    `ITDA_ASSERT(a_taken_goes_busy, start && !busy |=> busy, "busy not raised after a request")
    `ITDA_ASSERT(a_char_legal, strobe |-> char_ok, "illegal character")
    `ITDA_ASSERT(a_sign_not_last, strobe && (character == CHAR_MINUS) |-> !last, "sign marked last")
    `ITDA_ASSERT(a_last_frees, strobe && last |-> !busy, "still busy on final character")

endmodule

bind int_to_decimal_ascii_unit itda_checker u_itda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .strobe   (strobe),
    .character(character),
    .last     (last)
);
